/* rtl/cbsm_pkg.sv */
// Package with the mapper kinds, result codes, register indexes, hotspot offsets and widths of the bank mapper.
package cbsm_pkg;

	// Field and register widths.
	localparam int unsigned OffsetW = 12;
	localparam int unsigned DataW   = 8;
	localparam int unsigned BankW   = 4;
	localparam int unsigned AddrW   = 16;
	localparam int unsigned KindW   = 3;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned CfgIdxW = 2;

	// Default size of the extra RAM in bytes.
	localparam int unsigned ExtraRamDepthDef = 128;

	// Reset value of the ROM size mask (4 KiB).
	localparam logic [AddrW-1:0] RomMaskReset = 16'h0fff;

	// Mapper kinds; codes without a member behave as a flat 4K cartridge.
	typedef enum logic [KindW-1:0] {
		KIND_FLAT = 3'd0,
		KIND_F8   = 3'd1,
		KIND_F6   = 3'd2,
		KIND_F4   = 3'd3,
		KIND_F0   = 3'd4
	} kind_t;

	// Result source codes.
	typedef enum logic [1:0] {
		SRC_ZERO  = 2'd0,
		SRC_RAM   = 2'd1,
		SRC_ROM   = 2'd2,
		SRC_WRITE = 2'd3
	} source_t;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_MAPPER_KIND = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_EXTRA_RAM   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ROM_MASK    = 2'd2;

	// Hotspot offsets.
	localparam logic [OffsetW-1:0] HS_F8_LO = 12'hff8;
	localparam logic [OffsetW-1:0] HS_F8_HI = 12'hff9;
	localparam logic [OffsetW-1:0] HS_F6_LO = 12'hff6;
	localparam logic [OffsetW-1:0] HS_F4_LO = 12'hff4;
	localparam logic [OffsetW-1:0] HS_F4_HI = 12'hffb;
	localparam logic [OffsetW-1:0] HS_F0_LO = 12'hff0;
	localparam logic [OffsetW-1:0] HS_F0_HI = 12'hff7;

	// Highest bank number of a mapper kind, which is also its power-on bank.
	function automatic logic [BankW-1:0] last_bank(input logic [KindW-1:0] kind);
		logic [BankW-1:0] b;
		case (kind)
			KIND_F8: b = 4'd1;
			KIND_F6: b = 4'd3;
			KIND_F4: b = 4'd7;
			KIND_F0: b = 4'd15;
			default: b = 4'd0;
		endcase
		return b;
	endfunction

endpackage

/* rtl/cartridge_bank_switch_mapper_top.sv */
// Top level of the cartridge bank-switch mapper with its extra RAM and output register.
//
//  Channel   Handshake               Payload
//  in        in_valid / in_ready     func, offset, write_data
//  out       out_valid / out_ready   source, rom_address, read_data, current_bank
//  cfg       cfg_write               cfg_index, cfg_data
//
// The hotspot decode, bank update and RAM access all happen at the edge that accepts the
// item, and the result sits in the output register from the next cycle on. One item is
// accepted per cycle while the output is taken.
// Reset loads the default configuration and bank and clears one valid bit per RAM byte
// at once; a RAM byte not yet written reads as zero, so there is no clearing pass.
// While a result waits for out_ready, the input is held off and the RAM read data holds.
module cartridge_bank_switch_mapper_top
	import cbsm_pkg::*;
#(
	parameter int unsigned EXTRA_RAM_DEPTH = ExtraRamDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [OffsetW-1:0]  offset,
	input  logic [DataW-1:0]    write_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          source,
	output logic [AddrW-1:0]    rom_address,
	output logic [DataW-1:0]    read_data,
	output logic [BankW-1:0]    current_bank
);

	localparam int unsigned RamAw = $clog2(EXTRA_RAM_DEPTH);
	localparam logic [OffsetW-1:0] RamWinLo = OffsetW'(EXTRA_RAM_DEPTH);
	localparam logic [OffsetW-1:0] RamWinHi = OffsetW'(2 * EXTRA_RAM_DEPTH);

	// Configuration and bank registers.
	logic [KindW-1:0] kind_q;
	logic             ram_en_q;
	logic [AddrW-1:0] rom_mask_q;
	logic [BankW-1:0] bank_q;

	// Extra RAM and one valid bit per byte.
	logic [DataW-1:0]           ram_mem [EXTRA_RAM_DEPTH];
	logic [EXTRA_RAM_DEPTH-1:0] ram_vld_q;

	// Output stage.
	logic             valid_s1;
	source_t          source_s1;
	logic [AddrW-1:0] addr_s1;
	logic [DataW-1:0] rd_s1;
	logic             rd_vld_s1;
	logic [BankW-1:0] bank_s1;

	logic             accept;
	logic [BankW-1:0] bank_next;
	logic             hs_hit;
	logic [BankW-1:0] hs_bank;
	logic             in_ram_lo;
	logic             in_ram_hi;
	logic [RamAw-1:0] ram_idx;
	logic             ram_wr;
	source_t          source_next;
	logic [AddrW-1:0] addr_full;
	logic [AddrW-1:0] addr_next;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// Hotspot decode: the bank number is the offset minus the first hotspot.
	always_comb begin
		hs_hit  = 1'b0;
		hs_bank = '0;
		case (kind_q)
			KIND_F8: begin
				if (offset == HS_F8_LO || offset == HS_F8_HI) begin
					hs_hit  = 1'b1;
					hs_bank = offset[BankW-1:0] - HS_F8_LO[BankW-1:0];
				end
			end
			KIND_F6: begin
				if (offset >= HS_F6_LO && offset <= HS_F8_HI) begin
					hs_hit  = 1'b1;
					hs_bank = offset[BankW-1:0] - HS_F6_LO[BankW-1:0];
				end
			end
			KIND_F4: begin
				if (offset >= HS_F4_LO && offset <= HS_F4_HI) begin
					hs_hit  = 1'b1;
					hs_bank = offset[BankW-1:0] - HS_F4_LO[BankW-1:0];
				end
			end
			KIND_F0: begin
				if (offset >= HS_F0_LO && offset <= HS_F0_HI) begin
					hs_hit  = 1'b1;
					hs_bank = offset[BankW-1:0] - HS_F0_LO[BankW-1:0];
				end
			end
			default: begin
				hs_hit  = 1'b0;
				hs_bank = '0;
			end
		endcase
		// A bank beyond the last one of this kind is ignored.
		if (hs_hit && hs_bank <= last_bank(kind_q)) begin
			bank_next = hs_bank;
		end else begin
			bank_next = bank_q;
		end
	end

	// Region decode and ROM address of the access.
	always_comb begin
		in_ram_lo = ram_en_q && (offset < RamWinLo);
		in_ram_hi = ram_en_q && (offset < RamWinHi);
		ram_idx   = offset[RamAw-1:0];
		ram_wr    = accept && func && in_ram_lo;
		if (last_bank(kind_q) == '0) begin
			addr_full = AddrW'(offset);
		end else begin
			addr_full = {bank_next, offset};
		end
		addr_next = '0;
		if (func) begin
			source_next = SRC_WRITE;
		end else if (in_ram_lo) begin
			source_next = SRC_ZERO;
		end else if (in_ram_hi) begin
			source_next = SRC_RAM;
		end else begin
			source_next = SRC_ROM;
			addr_next   = addr_full & rom_mask_q;
		end
	end

	// Configuration registers and the bank; a new mapper kind restarts in its last bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_FLAT;
			ram_en_q   <= 1'b0;
			rom_mask_q <= RomMaskReset;
			bank_q     <= last_bank(KIND_FLAT);
		end else begin
			if (cfg_write && cfg_index == REG_MAPPER_KIND) begin
				kind_q <= cfg_data[KindW-1:0];
				bank_q <= last_bank(cfg_data[KindW-1:0]);
			end else if (accept) begin
				bank_q <= bank_next;
			end
			if (cfg_write && cfg_index == REG_EXTRA_RAM) begin
				ram_en_q <= cfg_data[0];
			end
			if (cfg_write && cfg_index == REG_ROM_MASK) begin
				rom_mask_q <= cfg_data[AddrW-1:0];
			end
		end
	end

	// RAM valid bits: a byte reads as zero until its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
		end else if (ram_wr) begin
			ram_vld_q[ram_idx] <= 1'b1;
		end
	end

	// RAM array: write on a write item to the RAM window, registered read on a read item.
	always_ff @(posedge clk) begin
		if (ram_wr) begin
			ram_mem[ram_idx] <= write_data;
		end
		if (accept && !func) begin
			rd_s1 <= ram_mem[ram_idx];
		end
	end

	// Output stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			source_s1 <= source_next;
			addr_s1   <= addr_next;
			rd_vld_s1 <= ram_vld_q[ram_idx];
			bank_s1   <= bank_next;
		end
	end

	assign out_valid    = valid_s1;
	assign source       = source_s1;
	assign rom_address  = addr_s1;
	assign read_data    = (source_s1 == SRC_RAM && rd_vld_s1) ? rd_s1 : '0;
	assign current_bank = bank_s1;

	// A write item always produces a write-done result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && func |=> out_valid && source == SRC_WRITE)
		else $error("write item did not produce a write-done result");

	// Only RAM reads carry data, and only ROM reads carry an address.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && source != SRC_RAM |-> read_data == '0)
		else $error("read data set on a result that is not a RAM read");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && source != SRC_ROM |-> rom_address == '0)
		else $error("ROM address set on a result that is not a ROM read");

	// The bank never exceeds the last bank of the current mapper kind.
	assert property (@(posedge clk) disable iff (!arst_n)
		bank_q <= last_bank(kind_q))
		else $error("bank register beyond the last bank of the mapper kind");

endmodule
